FILE: rtl/core/slot_pool_linked_allocator_defines.svh
// Assertion macros used by the slot pool allocator RTL.
`ifndef SLOT_POOL_LINKED_ALLOCATOR_DEFINES_SVH
`define SLOT_POOL_LINKED_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SPLA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SPLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/spla_pkg.sv
// Types and constants of the slot pool allocator.
package spla_pkg;

	localparam int unsigned SLOTS_DEF = 256;
	localparam int unsigned SLOT_W    = 8;
	localparam int unsigned COUNT_W   = 9;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_QUERY   = 2'd2,
		OP_REINIT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_EMPTY       = 2'd1,
		ST_PROTECTED   = 2'd2,
		ST_NOT_IN_USE  = 2'd3
	} status_t;

endpackage

FILE: rtl/core/slot_pool_linked_allocator.sv
// Slot pool allocator: free stack plus ordered active list held in two link RAMs.
//
//  channel   | handshake          | words
//  ----------+--------------------+------------------------------------------
//  command   | start, busy        | operation, slot
//  result    | done (one cycle)   | result_slot, result_valid, status, live_count
//
// Query and a refused allocate or release go from EXEC back to idle; allocate and
// release go on to LINK (read at accept, write-backs in EXEC and LINK; single write ports).
// Reinit sweeps both RAMs, one entry a cycle, then raises done.
// After reset the same clearing pass runs with busy high and no done.
// The result side cannot stall; done is high for exactly one cycle per word.
`include "slot_pool_linked_allocator_defines.svh"

module slot_pool_linked_allocator #(
	parameter int unsigned SLOTS = spla_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  spla_pkg::op_t                 operation,
	input  logic [spla_pkg::SLOT_W-1:0]   slot,
	output logic                          done,
	output logic [spla_pkg::SLOT_W-1:0]   result_slot,
	output logic                          result_valid,
	output spla_pkg::status_t             status,
	output logic [spla_pkg::COUNT_W-1:0]  live_count
);
	import spla_pkg::*;

	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned LW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] NONE = LW'(SLOTS);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_SWEEP
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [IW-1:0]    cur_q;
	logic             zero_q;
	logic             range_q;
	logic [LW-1:0]    fh_q;
	logic [LW-1:0]    tail_q;
	logic [LW-1:0]    count_q;
	logic [LW-1:0]    pv_q;
	logic [LW-1:0]    nx_q;
	logic [IW-1:0]    sweep_q;
	logic             rein_q;
	logic             done_q;
	logic [SLOT_W-1:0] rslot_q;
	logic             rvalid_q;
	status_t          status_q;

	// RAM ports
	logic             n_we;
	logic [IW-1:0]    n_wa;
	logic [LW-1:0]    n_wd;
	logic [LW-1:0]    n_rd;
	logic             p_we;
	logic [IW-1:0]    p_wa;
	logic [LW:0]      p_wd;
	logic [LW:0]      p_rd;
	logic [IW-1:0]    raddr;
	logic             p_used;
	logic [LW-1:0]    p_link;
	logic             in_range;
	logic             rel_ok;
	logic [LW-1:0]    sweep_link;

	// next links
	spla_ram #(.DEPTH(SLOTS), .WIDTH(LW)) u_next_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_wa),
		.wdata (n_wd),
		.raddr (raddr),
		.rdata (n_rd)
	);

	// in-use mark and prev link (free stack link for free slots)
	spla_ram #(.DEPTH(SLOTS), .WIDTH(LW + 1)) u_prev_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_wa),
		.wdata (p_wd),
		.raddr (raddr),
		.rdata (p_rd)
	);

	assign p_used   = p_rd[LW];
	assign p_link   = p_rd[LW-1:0];
	assign in_range = 32'(slot) < SLOTS;
	assign rel_ok   = range_q && !zero_q && p_used;

	// read address is taken at the accept edge
	assign raddr = (operation == OP_ALLOC) ? fh_q[IW-1:0] : IW'(slot);

	// free chain built by the sweep: i to i+1, slot 0 and the last slot end it
	assign sweep_link = (sweep_q == '0 || sweep_q == LAST) ? NONE
	                  : LW'(sweep_q) + LW'(1);

	// write-back of both RAMs
	always_comb begin
		n_we = 1'b0;
		n_wa = cur_q;
		n_wd = NONE;
		p_we = 1'b0;
		p_wa = cur_q;
		p_wd = {1'b0, NONE};
		unique case (state_q)
			S_SWEEP: begin
				n_we = 1'b1;
				n_wa = sweep_q;
				p_we = 1'b1;
				p_wa = sweep_q;
				p_wd = {sweep_q == '0, sweep_link};
			end
			S_EXEC: begin
				if (op_q == OP_ALLOC && fh_q != NONE) begin
					// popped slot joins the tail, end of list
					p_we = 1'b1;
					p_wd = {1'b1, tail_q};
					n_we = 1'b1;
				end else if (op_q == OP_RELEASE && rel_ok) begin
					// push on the free stack, bridge predecessor forward
					p_we = 1'b1;
					p_wd = {1'b0, fh_q};
					if (p_link != NONE) begin
						n_we = 1'b1;
						n_wa = p_link[IW-1:0];
						n_wd = n_rd;
					end
				end
			end
			S_LINK: begin
				if (op_q == OP_ALLOC) begin
					if (tail_q != NONE) begin
						n_we = 1'b1;
						n_wa = tail_q[IW-1:0];
						n_wd = LW'(cur_q);
					end
				end else if (LW'(cur_q) != tail_q && nx_q != NONE) begin
					// successor of a released slot is active, keep its mark
					p_we = 1'b1;
					p_wa = nx_q[IW-1:0];
					p_wd = {1'b1, pv_q};
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			op_q     <= OP_QUERY;
			cur_q    <= '0;
			zero_q   <= 1'b0;
			range_q  <= 1'b0;
			fh_q     <= LW'(1);
			tail_q   <= '0;
			count_q  <= LW'(1);
			pv_q     <= NONE;
			nx_q     <= NONE;
			sweep_q  <= '0;
			rein_q   <= 1'b0;
			done_q   <= 1'b0;
			rslot_q  <= '0;
			rvalid_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= operation;
						cur_q   <= raddr;
						zero_q  <= (slot == '0);
						range_q <= in_range;
						if (operation == OP_REINIT) begin
							state_q <= S_SWEEP;
							sweep_q <= '0;
							rein_q  <= 1'b1;
							fh_q    <= LW'(1);
							tail_q  <= '0;
							count_q <= LW'(1);
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					rslot_q  <= '0;
					rvalid_q <= 1'b0;
					status_q <= ST_OK;
					unique case (op_q)
						OP_ALLOC: begin
							if (fh_q == NONE) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								fh_q    <= p_link;
								state_q <= S_LINK;
							end
						end
						OP_RELEASE: begin
							if (zero_q) begin
								status_q <= ST_PROTECTED;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (!rel_ok) begin
								status_q <= ST_NOT_IN_USE;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								fh_q    <= LW'(cur_q);
								pv_q    <= p_link;
								nx_q    <= n_rd;
								state_q <= S_LINK;
							end
						end
						OP_QUERY: begin
							if (!range_q) begin
								status_q <= ST_NOT_IN_USE;
							end else begin
								// a free slot still reports its kept next link
								if (n_rd != NONE) begin
									rslot_q  <= SLOT_W'(n_rd);
									rvalid_q <= 1'b1;
								end
								if (!p_used) begin
									status_q <= ST_NOT_IN_USE;
								end
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						OP_REINIT: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_LINK: begin
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
					status_q <= ST_OK;
					if (op_q == OP_ALLOC) begin
						tail_q   <= LW'(cur_q);
						count_q  <= count_q + LW'(1);
						rslot_q  <= SLOT_W'(cur_q);
						rvalid_q <= 1'b1;
					end else begin
						if (LW'(cur_q) == tail_q) begin
							tail_q <= pv_q;
						end
						if (count_q != '0) begin
							count_q <= count_q - LW'(1);
						end
						rslot_q  <= '0;
						rvalid_q <= 1'b0;
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + IW'(1);
					if (sweep_q == LAST) begin
						state_q <= S_IDLE;
						rein_q  <= 1'b0;
						if (rein_q) begin
							done_q   <= 1'b1;
							rslot_q  <= '0;
							rvalid_q <= 1'b1;
							status_q <= ST_OK;
						end
					end
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign result_slot  = rslot_q;
	assign result_valid = rvalid_q;
	assign status       = status_q;
	assign live_count   = COUNT_W'(count_q);

	// checks
	`SPLA_ASSERT_NOW(a_done_when_idle, done, state_q == S_IDLE, "result word outside idle")
	`SPLA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
	`SPLA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= NONE, "live count beyond pool size")
	`SPLA_ASSERT_NOW(a_empty_full, state_q == S_IDLE && fh_q == NONE, count_q == NONE, "free stack empty but pool not full")

endmodule

FILE: rtl/core/spla_ram.sv
// Single-write, single-read synchronous RAM with registered read data.
module spla_ram #(
	parameter int unsigned DEPTH = spla_pkg::SLOTS_DEF,
	parameter int unsigned WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	import spla_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
